/* hdl/assert_macros.svh */
// Assertion helper macros shared by the RTL of the Annex B splitter.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, with the default clock and reset names of this project.
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

/* hdl/anbs_pkg.sv */
// Shared types and constants of the Annex B unit splitter.
// No dependencies; imported by annexb_nal_unit_splitter_core.
`default_nettype none

package anbs_pkg;

  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned OutDataW  = 104;

  // Register index, taken from paddr[2]
  localparam logic REG_MAX_NAL_BYTES = 1'b0;

  localparam logic [23:0] MAX_NAL_RESET = 24'd100000;
  localparam logic [23:0] HIST_RESET    = 24'hFFFFFF;
  localparam logic [2:0]  PREFIX_THREE  = 3'd3;
  localparam logic [2:0]  PREFIX_FOUR   = 3'd4;

  // Result word, lowest field last (packed structs fill from the MSB)
  typedef struct packed {
    logic [2:0]  pad;
    logic        skipped_leading_flag;
    logic        oversize_flag;
    logic [23:0] payload_length;
    logic [4:0]  unit_type;
    logic [1:0]  reference_priority;
    logic        forbidden_flag;
    logic [2:0]  prefix_length;
    logic [31:0] start_offset;
    logic [31:0] unit_index;
  } result_t;

endpackage

`default_nettype wire

/* hdl/annexb_nal_unit_splitter_core.sv */
// H.264 Annex B start-code splitter: one stream byte per word, one unit report out.
// Depends on anbs_pkg and assert_macros.svh.
//
// Usage:
// - Input stream: one raw bitstream byte per word on s_axis_tdata; s_axis_tlast
//   marks the final byte of a stream. The next byte after it starts a new
//   stream at offset 0 with all counters cleared.
// - Output stream: one word per completed unit on m_axis_tdata, issued when the
//   next start code completes or when the stream ends.
// - Configuration: APB register 0 (address 0) holds max_nal_bytes, the
//   saturation limit of the payload length. Reset value 100000. Write only
//   while no words are in flight.
// - Output: each report is registered in the output register or, on a stall, the skid register.
// - Throughput: one byte per cycle while s_axis_tready is high. All per-byte work (history compare, one
//   24-bit add and compare, header capture) sits between the accept edge and
//   the state and result registers.
// - Stall: an output register plus a one-word skid register let the block take
//   a byte while one report waits; s_axis_tready drops only while the skid
//   register is full.
// - Reset: asynchronous, active low; clears the parser state, the output
//   queue and restores max_nal_bytes to 100000.
`default_nettype none

`include "assert_macros.svh"

module annexb_nal_unit_splitter_core
  import anbs_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // stream in
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // [7:0] stream_byte
  input  wire logic                  s_axis_tlast,   // end_of_stream
  // stream out
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [31:0] unit_index, [63:32] start_offset, [66:64] prefix_length,
  // [67] forbidden_flag, [69:68] reference_priority, [74:70] unit_type,
  // [98:75] payload_length, [99] oversize_flag, [100] skipped_leading_flag,
  // [103:101] zero
  output logic [OutDataW-1:0]        m_axis_tdata,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CfgAddrW-1:0]   paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [23:0] max_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_NAL_BYTES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_NAL_RESET;
    end else if (cfg_wr) begin
      max_q <= pwdata[23:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_MAX_NAL_BYTES) begin
      prdata = {8'd0, max_q};
    end
  end

  // ---------------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------------
  logic [23:0] hist_q,   hist_d;     // last three bytes, newest lowest
  logic        inside_q, inside_d;
  logic [2:0]  pfx_q,    pfx_d;
  logic [31:0] start_q,  start_d;
  logic [31:0] hdr_pos_q, hdr_pos_d; // offset of the header byte of the open unit
  logic [23:0] count_q,  count_d;
  logic [7:0]  header_q, header_d;
  logic [31:0] pos_q,    pos_d;
  logic [31:0] units_q,  units_d;
  logic        skip_q,   skip_d;
  logic        ovf_q,    ovf_d;

  logic        in_acc;
  logic [7:0]  b;
  logic        eos;
  logic [1:0]  zeros;                // trailing zero bytes in the history
  logic        four, three, sc;
  logic [2:0]  pfx_new;
  logic [31:0] open_start;
  logic [7:0]  hdr_eff;
  logic [2:0]  add_amt;
  logic [24:0] sum;
  logic        over;
  logic [23:0] cnt_new;
  logic        ovf_new;

  // Result selection
  logic        emit;
  logic [23:0] em_count;
  logic        em_ovf;
  logic [7:0]  em_hdr;
  logic [31:0] em_start;
  logic [2:0]  em_pfx;
  logic        em_skip;
  logic        em_empty;
  logic [7:0]  hdr_out;
  result_t     res;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign b      = s_axis_tdata;
  assign eos    = s_axis_tlast;

  always_comb begin
    if (hist_q[7:0] != 8'd0) begin
      zeros = 2'd0;
    end else if (hist_q[15:8] != 8'd0) begin
      zeros = 2'd1;
    end else if (hist_q[23:16] != 8'd0) begin
      zeros = 2'd2;
    end else begin
      zeros = 2'd3;
    end
  end

  // Prefer the four-byte start code when both end on this byte
  assign four       = (hist_q == 24'd0) && (b == 8'd1);
  assign three      = !four && (hist_q[15:0] == 16'd0) && (b == 8'd1);
  assign sc         = four || three;
  assign pfx_new    = four ? PREFIX_FOUR : PREFIX_THREE;
  assign open_start = pos_q - {29'd0, pfx_new - 3'd1};

  assign hdr_eff = (inside_q && (pos_q == hdr_pos_q)) ? b : header_q;

  // Pending trailing zeros count once a nonzero byte follows, they leave the window or the stream ends
  always_comb begin
    if (eos || (b != 8'd0)) begin
      add_amt = {1'b0, zeros} + 3'd1;
    end else begin
      add_amt = (zeros == 2'd3) ? 3'd1 : 3'd0;
    end
  end

  assign sum     = {1'b0, count_q} + {22'd0, add_amt};
  assign over    = sum > {1'b0, max_q};
  assign cnt_new = over ? max_q : sum[23:0];
  assign ovf_new = ovf_q || over;

  always_comb begin
    emit     = 1'b0;
    em_count = count_q;
    em_ovf   = ovf_q;
    em_hdr   = hdr_eff;
    em_start = start_q;
    em_pfx   = pfx_q;
    em_skip  = skip_q;
    if (inside_q) begin
      if (sc) begin
        emit = 1'b1;
      end else if (eos) begin
        emit     = 1'b1;
        em_count = cnt_new;
        em_ovf   = ovf_new;
      end
    end else if (sc && eos) begin
      // start code on the final byte opens and closes an empty unit
      emit     = 1'b1;
      em_count = 24'd0;
      em_ovf   = 1'b0;
      em_hdr   = 8'd0;
      em_start = open_start;
      em_pfx   = pfx_new;
      em_skip  = skip_q || (open_start != 32'd0);
    end
  end

  assign em_empty = (em_count == 24'd0) && !em_ovf;
  assign hdr_out  = em_empty ? 8'd0 : em_hdr;

  always_comb begin
    res                      = '0;
    res.unit_index           = units_q;
    res.start_offset         = em_start;
    res.prefix_length        = em_pfx;
    res.forbidden_flag       = hdr_out[7];
    res.reference_priority   = hdr_out[6:5];
    res.unit_type            = hdr_out[4:0];
    res.payload_length       = em_count;
    res.oversize_flag        = em_ovf;
    res.skipped_leading_flag = em_skip;
  end

  // Next state for one accepted byte
  always_comb begin
    hist_d    = hist_q;
    inside_d  = inside_q;
    pfx_d     = pfx_q;
    start_d   = start_q;
    hdr_pos_d = hdr_pos_q;
    count_d   = count_q;
    header_d  = header_q;
    pos_d     = pos_q;
    units_d   = units_q;
    skip_d    = skip_q;
    ovf_d     = ovf_q;
    if (in_acc) begin
      if (eos) begin
        // drop all stream state; the next byte starts a fresh stream
        hist_d    = HIST_RESET;
        inside_d  = 1'b0;
        pfx_d     = PREFIX_THREE;
        start_d   = 32'd0;
        hdr_pos_d = 32'd0;
        count_d   = 24'd0;
        header_d  = 8'd0;
        pos_d     = 32'd0;
        units_d   = 32'd0;
        skip_d    = 1'b0;
        ovf_d     = 1'b0;
      end else begin
        hist_d = {hist_q[15:0], b};
        pos_d  = pos_q + 32'd1;
        if (inside_q) begin
          header_d = hdr_eff;
          if (!sc) begin
            count_d = cnt_new;
            ovf_d   = ovf_new;
          end
        end
        if (sc) begin
          inside_d  = 1'b1;
          pfx_d     = pfx_new;
          start_d   = open_start;
          hdr_pos_d = pos_q + 32'd1;
          count_d   = 24'd0;
          header_d  = 8'd0;
          ovf_d     = 1'b0;
          if (inside_q) begin
            units_d = units_q + 32'd1;
          end else begin
            skip_d = skip_q || (open_start != 32'd0);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q    <= HIST_RESET;
      inside_q  <= 1'b0;
      pfx_q     <= PREFIX_THREE;
      start_q   <= 32'd0;
      hdr_pos_q <= 32'd0;
      count_q   <= 24'd0;
      header_q  <= 8'd0;
      pos_q     <= 32'd0;
      units_q   <= 32'd0;
      skip_q    <= 1'b0;
      ovf_q     <= 1'b0;
    end else begin
      hist_q    <= hist_d;
      inside_q  <= inside_d;
      pfx_q     <= pfx_d;
      start_q   <= start_d;
      hdr_pos_q <= hdr_pos_d;
      count_q   <= count_d;
      header_q  <= header_d;
      pos_q     <= pos_d;
      units_q   <= units_d;
      skip_q    <= skip_d;
      ovf_q     <= ovf_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with one-word skid
  // ---------------------------------------------------------------------------
  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    new_res;

  assign new_res       = in_acc && emit;
  assign s_axis_tready = !skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || m_axis_tready) begin
      // output free this cycle: advance skid first, else take the new word
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (new_res) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (new_res) begin
      // receiver stalls: hold the waiting word, park the new one
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `ASSERT_STD(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid full with output empty")
  `ASSERT_STD(a_skid_only_on_stall, $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready), "skid loaded without stall")
  `ASSERT_STD(a_eos_clears, (in_acc && eos) |=> (!inside_q && (pos_q == 32'd0) && (units_q == 32'd0)), "stream state not cleared after final byte")
  `ASSERT_STD(a_open_prefix, inside_q |-> ((pfx_q == PREFIX_THREE) || (pfx_q == PREFIX_FOUR)), "open unit with bad prefix length")

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for annexb_nal_unit_splitter_core: directed and random byte
// streams in, unit reports checked against an in-bench start-code parser model or typed-in rows.
// Depends on anbs_pkg and the core RTL only.

module tb;
  import anbs_pkg::*;

  // One stimulus word. Rows with fixed set carry their expected report (or none)
  // typed in by hand; all other words are checked against the parser model.
  typedef struct packed {
    logic [7:0] b;
    logic       l;
    logic       fixed;
    logic       emits;
    result_t    res;
  } stim_t;

  localparam result_t NO_RESULT = '0;
  localparam int      PHASES = 8;
  localparam int      PHASE_WORDS = 190;
  localparam int      PRESSURE_PHASE = 4;
  localparam int      HOLD_CYCLES = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  wire                 s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;   // [7:0] stream_byte
  logic                s_axis_tlast = 1'b0; // end_of_stream
  wire                 m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  wire [OutDataW-1:0]  m_axis_tdata;        // result_t layout, unit_index lowest
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [31:0]         pwdata = '0;
  wire  [31:0]         prdata;
  wire                 pready;

  annexb_nal_unit_splitter_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser model: own copy of the limit register and the per-stream state.
  // ---------------------------------------------------------------------------
  logic [23:0] length_limit = MAX_NAL_RESET;
  logic [23:0] hist;          // last three bytes, newest in the low byte
  bit          in_unit;
  logic [2:0]  cur_prefix;
  logic [31:0] cur_start;
  logic [23:0] nbytes;        // payload bytes confirmed, held at the limit
  logic [7:0]  hdr;
  logic [31:0] stream_pos;
  logic [31:0] units_seen;
  bit          skipped;
  bit          overflowed;

  stim_t   offered_words[$];   // words on offer, popped as they are accepted
  result_t pending_reports[$]; // reports still owed by the block
  stim_t   stream_q[$];
  int      fail_count = 0;
  int      send_gap_pct = 0;
  int      stall_pct = 0;
  int      hold_left = 0;
  bit      hold_req = 1'b0;    // stimulus asks for one long receiver hold-off
  bit      hold_done = 1'b0;

  function automatic result_t unit_word(input logic [31:0] idx, input logic [31:0] off,
                                        input logic [2:0] pfx, input logic [7:0] header,
                                        input logic [23:0] len, input logic ov,
                                        input logic sk);
    result_t r;
    r = NO_RESULT;
    r.unit_index = idx;
    r.start_offset = off;
    r.prefix_length = pfx;
    r.forbidden_flag = header[7];
    r.reference_priority = header[6:5];
    r.unit_type = header[4:0];
    r.payload_length = len;
    r.oversize_flag = ov;
    r.skipped_leading_flag = sk;
    return r;
  endfunction

  function automatic void clear_stream();
    hist = HIST_RESET;
    in_unit = 1'b0;
    cur_prefix = PREFIX_THREE;
    cur_start = '0;
    nbytes = '0;
    hdr = '0;
    stream_pos = '0;
    units_seen = '0;
    skipped = 1'b0;
    overflowed = 1'b0;
  endfunction

  // Add confirmed payload bytes, saturating at the limit.
  function automatic void tally(input int unsigned add);
    logic [31:0] sum;
    sum = 32'(nbytes) + add;
    if (sum > 32'(length_limit)) begin
      overflowed = 1'b1;
      sum = 32'(length_limit);
    end
    nbytes = sum[23:0];
  endfunction

  function automatic result_t close_unit();
    result_t r;
    bit empty;
    empty = (nbytes == 0) && !overflowed;
    r = unit_word(units_seen, cur_start, cur_prefix, empty ? 8'h00 : hdr, nbytes,
                  overflowed, skipped);
    units_seen = units_seen + 1;
    return r;
  endfunction

  function automatic void open_unit(input logic [31:0] at, input bit four);
    in_unit = 1'b1;
    cur_prefix = four ? PREFIX_FOUR : PREFIX_THREE;
    cur_start = at - 32'(cur_prefix) + 32'd1;
    nbytes = '0;
    hdr = '0;
    overflowed = 1'b0;
  endfunction

  // Advance the model by one stream byte; returns 1 when a unit report falls out.
  function automatic bit parse_byte(input logic [7:0] b, input logic l, output result_t rpt);
    logic [23:0] h;
    logic [31:0] at;
    int unsigned zeros;
    bit four;
    bit three;
    bit fired;
    h = hist;
    at = stream_pos;
    fired = 1'b0;
    rpt = NO_RESULT;
    // Trailing zeros held back because they may open the next start code
    if (h[7:0] != 0) zeros = 0;
    else if (h[15:8] != 0) zeros = 1;
    else if (h[23:16] != 0) zeros = 2;
    else zeros = 3;
    four = (h == 0) && (b == 8'h01);
    three = !four && (h[15:0] == 0) && (b == 8'h01);
    if (in_unit) begin
      if (at == cur_start + 32'(cur_prefix)) hdr = b;
      if (four || three) begin
        rpt = close_unit();
        fired = 1'b1;
        open_unit(at, four);
      end else if (l) begin
        tally(zeros + 1);
        rpt = close_unit();
        fired = 1'b1;
      end else if (b == 8'h00) begin
        // a zero pushed out of the four-byte window can no longer be a prefix
        tally(zeros == 3 ? 1 : 0);
      end else begin
        tally(zeros + 1);
      end
    end else if (four || three) begin
      open_unit(at, four);
      if (cur_start != 0) skipped = 1'b1;
      // start code on the final byte: report the empty unit it opens
      if (l) begin
        rpt = close_unit();
        fired = 1'b1;
      end
    end
    hist = {h[15:0], b};
    stream_pos = at + 32'd1;
    if (l) clear_stream();
    return fired;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: input acceptance feeds the model first, then output words are
  // checked against the oldest owed report. Both use pre-edge values.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    stim_t   row;
    result_t rpt;
    result_t got;
    result_t want;
    bit      fired;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        row = offered_words.pop_front();
        fired = parse_byte(s_axis_tdata, s_axis_tlast, rpt);
        if (row.fixed) begin
          if (row.emits) pending_reports.push_back(row.res);
        end else if (fired) begin
          pending_reports.push_back(rpt);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata);
        if (pending_reports.size() == 0) begin
          $error("unexpected report word %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = pending_reports.pop_front();
          check_field("unit_index", want.unit_index, got.unit_index);
          check_field("start_offset", want.start_offset, got.start_offset);
          check_field("prefix_length", 32'(want.prefix_length), 32'(got.prefix_length));
          check_field("forbidden_flag", 32'(want.forbidden_flag), 32'(got.forbidden_flag));
          check_field("reference_priority", 32'(want.reference_priority),
                      32'(got.reference_priority));
          check_field("unit_type", 32'(want.unit_type), 32'(got.unit_type));
          check_field("payload_length", 32'(want.payload_length), 32'(got.payload_length));
          check_field("oversize_flag", 32'(want.oversize_flag), 32'(got.oversize_flag));
          check_field("skipped_leading_flag", 32'(want.skipped_leading_flag),
                      32'(got.skipped_leading_flag));
          check_field("pad", 32'(want.pad), 32'(got.pad));
        end
      end
    end
  end

  // Receiver: start the requested hold-off once and count it down here;
  // otherwise stall at random.
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  task automatic send_word(input stim_t w);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    offered_words.push_back(w);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w.b;
    s_axis_tlast <= w.l;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid and wait until every offered word and owed report is through,
  // then idle on with valid low.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (offered_words.size() != 0 || pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_length_limit(input logic [23:0] lim);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_MAX_NAL_BYTES, 2'b00};
    pwdata <= {8'h00, lim};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    length_limit = lim;
  endtask

  // Zero-heavy byte mix so that start codes and trailing zeros turn up often.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(5))
      0, 1: return 8'h00;
      2: return 8'h01;
      3: return 8'h03;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void add_word(input logic [7:0] b);
    stream_q.push_back('{b: b, l: 1'b0, fixed: 1'b0, emits: 1'b0, res: NO_RESULT});
  endfunction

  // Build one stream: mostly well-formed units with random content, some noise
  // and some broken start codes. The last word always carries tlast.
  task automatic build_stream(input bit short_units);
    int n_units;
    int plen;
    stream_q = {};
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 30)) add_word(rand_byte());
    end else begin
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) add_word(8'($urandom_range(255)));
      n_units = $urandom_range(1, 5);
      for (int u = 0; u < n_units; u++) begin
        if ($urandom_range(1) == 1) add_word(8'h00);
        add_word(8'h00);
        // broken prefix: a single zero before the one
        if ($urandom_range(11) != 0) add_word(8'h00);
        add_word(8'h01);
        if (u == n_units - 1 && $urandom_range(7) == 0) break;
        if ($urandom_range(7) != 0) begin
          add_word(8'($urandom_range(255)));
          if (short_units) plen = $urandom_range(0, 2);
          else if ($urandom_range(7) == 0) plen = $urandom_range(20, 60);
          else plen = $urandom_range(0, 10);
          repeat (plen) add_word(rand_byte());
        end
      end
    end
    stream_q[$].l = 1'b1;
  endtask

  // Directed streams: the first three rows of typed reports are the easy ones.
  stim_t directed_rows [28] = '{
    // three-byte code at 0, header with every bit set, one payload byte,
    // then a four-byte code and a unit cut by the end of the stream
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, 1'b1, 1'b1,
      unit_word(32'd0, 32'd0, PREFIX_THREE, 8'hFF, 24'd1, 1'b0, 1'b0)},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h01, 1'b1, 1'b1, 1'b1,
      unit_word(32'd1, 32'd4, PREFIX_FOUR, 8'h00, 24'd2, 1'b0, 1'b0)},
    // leading junk, start code on the final byte: empty unit, skip flagged
    '{8'h55, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h01, 1'b1, 1'b1, 1'b1,
      unit_word(32'd0, 32'd1, PREFIX_THREE, 8'h00, 24'd0, 1'b0, 1'b1)},
    // no start code at all: nothing reported
    '{8'hAA, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h01, 1'b1, 1'b1, 1'b0, NO_RESULT},
    // a zero pushed out ahead of a four-byte code, trailing zero at the end
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h41, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h7F, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, 1'b0, 1'b0, NO_RESULT}
  };

  // Limits per random phase; zero picks a small random limit.
  int unsigned phase_limits [PHASES] = '{1, 16777215, 5, 100000, 12, 0, 3, 0};

  initial begin : stimulus
    int sent;
    int unsigned lim;
    clear_stream();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset limit, no idling
    foreach (directed_rows[i]) send_word(directed_rows[i]);

    for (int p = 0; p < PHASES; p++) begin
      lim = (phase_limits[p] != 0) ? phase_limits[p] : $urandom_range(2, 64);
      set_length_limit(lim[23:0]);
      // idle mix: none, sender 86%, receiver 86%, both 35%
      case (p % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 86; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 86; end
        default: begin send_gap_pct = 35; stall_pct = 35; end
      endcase
      // long receiver hold while short units keep coming: fills the skid and
      // backs up the input
      if (p == PRESSURE_PHASE) hold_req <= 1'b1;
      sent = 0;
      while (sent < PHASE_WORDS) begin
        build_stream(p == PRESSURE_PHASE);
        foreach (stream_q[i]) send_word(stream_q[i]);
        sent += stream_q.size();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/anbs_pkg.sv
hdl/annexb_nal_unit_splitter_core.sv
tb/sv/tb.sv
